// ===== rtl/core/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// shared types and constants of the bakhshali square root unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int LIMIT_WIDTH = 8;

   // register indexes of the csr port
   localparam logic CSR_EPSILON    = 1'b0;
   localparam logic CSR_ITER_LIMIT = 1'b1;

   localparam logic [FIELD_WIDTH-1:0] EPSILON_RESET    = 32'd6554;
   localparam logic [LIMIT_WIDTH-1:0] ITER_LIMIT_RESET = 8'd16;

   typedef enum logic {
      MD_MUL = 1'b0,
      MD_DIV = 1'b1
   } md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_ctrl_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } md_stat_type;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_CHECK  = 11'b000_0000_0010,
      ST_SQ     = 11'b000_0000_0100,
      ST_RES    = 11'b000_0000_1000,
      ST_TEST   = 11'b000_0001_0000,
      ST_DIV1   = 11'b000_0010_0000,
      ST_BCALC  = 11'b000_0100_0000,
      ST_MUL2   = 11'b000_1000_0000,
      ST_DIV2   = 11'b001_0000_0000,
      ST_FINISH = 11'b010_0000_0000,
      ST_SPARE  = 11'b100_0000_0000
   } bsr_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/bsr_req_if.sv =====
// ----------------------------------------------------------------------------
// bsr_req_if
// request channel: radicand and starting guess
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] radicand;
   logic [31:0] start_guess;

   modport source (output valid, output radicand, output start_guess, input ready);
   modport sink (input valid, input radicand, input start_guess, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bsr_rsp_if
// response channel: root and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] root;
   logic        converged;
   logic        div_error;
   logic [7:0]  steps_used;

   modport source (output valid, output root, output converged, output div_error,
                   output steps_used, input ready);
   modport sink (input valid, input root, input converged, input div_error,
                 input steps_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsr_muldiv.sv =====
// ----------------------------------------------------------------------------
// bsr_muldiv
// shared shift-add multiplier and restoring divider on one adder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsr_muldiv
   import bsr_pkg::*;
#(
   parameter int VW = 32,
   parameter int NW = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire md_ctrl_type       ctrl,
   input  wire logic [VW-1:0]     mul_a,
   input  wire logic [VW-1:0]     mul_b,
   input  wire logic [NW-1:0]     div_num,
   input  wire logic [VW+1:0]     div_den,
   output md_stat_type            stat,
   output logic [2*VW-1:0]        product,
   output logic [VW:0]            quotient
);

   localparam int PW   = 2 * VW;
   localparam int HW   = NW - VW - 1;
   localparam int REMW = VW + 2;
   localparam int AW0  = (PW > HW) ? PW : HW;
   localparam int AW   = (AW0 > REMW + 1) ? AW0 : REMW + 1;
   localparam int CW   = $clog2(VW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            ovf_ff, ovf_in;
   md_op_type       op_ff, op_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [PW-1:0]   acc_ff, acc_in;
   logic [PW-1:0]   mb_ff, mb_in;
   logic [VW-1:0]   ma_ff, ma_in;
   logic [REMW-1:0] rem_ff, rem_in;
   logic [REMW-1:0] den_ff, den_in;
   logic [VW:0]     num_ff, num_in;
   logic [VW:0]     quo_ff, quo_in;

   logic [AW-1:0]   add_x, add_y;
   logic            add_cin;
   logic [AW:0]     add_sum;
   logic            carry;

   // the one adder, shared by all operations
   always_comb begin
      if (!busy_ff) begin
         add_x   = AW'(div_num >> (VW + 1));
         add_y   = ~AW'(div_den);
         add_cin = 1'b1;
      end else if (op_ff == MD_MUL) begin
         add_x   = AW'(acc_ff);
         add_y   = AW'(mb_ff);
         add_cin = 1'b0;
      end else begin
         add_x   = AW'({rem_ff, num_ff[VW]});
         add_y   = ~AW'(den_ff);
         add_cin = 1'b1;
      end
      add_sum = (AW+1)'(add_x) + (AW+1)'(add_y) + (AW+1)'(add_cin);
      carry   = add_sum[AW];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mb_in   = mb_ff;
      ma_in   = ma_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (!busy_ff) begin
         if (ctrl.start) begin
            op_in = ctrl.op;
            if (ctrl.op == MD_MUL) begin
               busy_in = 1'b1;
               ovf_in  = 1'b0;
               cnt_in  = CW'(VW - 1);
               acc_in  = '0;
               mb_in   = PW'(mul_b);
               ma_in   = mul_a;
            end else if (carry) begin
               // quotient does not fit in VW+1 bits
               done_in = 1'b1;
               ovf_in  = 1'b1;
            end else begin
               busy_in = 1'b1;
               ovf_in  = 1'b0;
               cnt_in  = CW'(VW);
               rem_in  = add_x[REMW-1:0];
               den_in  = div_den;
               num_in  = div_num[VW:0];
               quo_in  = '0;
            end
         end
      end else begin
         if (op_ff == MD_MUL) begin
            if (ma_ff[0]) begin
               acc_in = add_sum[PW-1:0];
            end
            mb_in = mb_ff << 1;
            ma_in = ma_ff >> 1;
         end else begin
            rem_in = carry ? add_sum[REMW-1:0] : add_x[REMW-1:0];
            quo_in = {quo_ff[VW-1:0], carry};
            num_in = num_ff << 1;
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mb_ff  <= mb_in;
      ma_ff  <= ma_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign product   = acc_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bakhshali_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// bakhshali_square_root_unit
// iterative bakhshali square root refinement in unsigned fixed point
// ----------------------------------------------------------------------------
// throughput: one transaction at a time; the shared multiply/divide unit
//   runs two multiplies and two divides per step, one bit per cycle
// reset: synchronous active high; epsilon back to 6554, limit to 16,
//   sequencer idle and no response pending
`timescale 1ns / 1ps
`default_nettype none

module bakhshali_square_root_unit
   import bsr_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bsr_req_if.sink          req_chan,
   bsr_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);

   localparam int VW  = VALUE_WIDTH;
   // residual width: covers x*x, s << frac and epsilon << frac
   localparam int RW0 = (2 * VW > VW + FRAC_BITS) ? 2 * VW : VW + FRAC_BITS;
   localparam int RW  = (RW0 > FIELD_WIDTH + FRAC_BITS) ? RW0 : FIELD_WIDTH + FRAC_BITS;
   localparam logic [VW-1:0] VMAX = '1;

   // control registers
   logic [FIELD_WIDTH-1:0] eps_ff, eps_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;

   // sequencer and datapath registers
   bsr_state_type          state_ff, state_in;
   logic [VW-1:0]          s_ff, s_in;
   logic [VW-1:0]          x_ff, x_in;
   logic [VW:0]            b_ff, b_in;
   logic [RW-1:0]          res_ff, res_in;
   logic                   neg_ff, neg_in;
   logic [LIMIT_WIDTH-1:0] steps_ff, steps_in;
   logic                   conv_ff, conv_in;
   logic                   derr_ff, derr_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            root_ff, root_in;
   logic                   rconv_ff, rconv_in;
   logic                   rderr_ff, rderr_in;
   logic [7:0]             rsteps_ff, rsteps_in;

   // shared unit hookup
   md_ctrl_type            md_ctrl;
   md_stat_type            md_stat;
   logic [VW-1:0]          mul_a;
   logic [RW-1:0]          div_num;
   logic [VW+1:0]          div_den;
   logic [2*VW-1:0]        md_prod;
   logic [VW:0]            md_quo;

   // datapath helpers
   logic [RW-1:0]          sq_ext, s_al, eps_al;
   logic [RW:0]            diff;
   logic [VW-1:0]          a_val;
   logic [VW:0]            b_val, xn_diff;

   bsr_muldiv #(
      .VW (VW),
      .NW (RW)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (md_ctrl),
      .mul_a    (mul_a),
      .mul_b    (mul_a),
      .div_num  (div_num),
      .div_den  (div_den),
      .stat     (md_stat),
      .product  (md_prod),
      .quotient (md_quo)
   );

   // config register writes
   always_comb begin
      eps_in   = eps_ff;
      limit_in = limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_EPSILON:    eps_in   = csr_write_data;
            CSR_ITER_LIMIT: limit_in = csr_write_data[LIMIT_WIDTH-1:0];
            default:        eps_in   = eps_ff;
         endcase
      end
   end

   // residual |x*x - s|, aligned to 2*frac bits
   always_comb begin
      sq_ext = RW'(md_prod);
      s_al   = RW'(s_ff) << FRAC_BITS;
      eps_al = RW'(eps_ff) << FRAC_BITS;
      diff   = {1'b0, sq_ext} - {1'b0, s_al};
   end

   // correction a saturated, then b = x +/- a
   always_comb begin
      a_val = (md_stat.ovf || md_quo[VW]) ? VMAX : md_quo[VW-1:0];
      if (neg_ff) begin
         b_val = (a_val >= x_ff) ? '0 : {1'b0, x_ff} - {1'b0, a_val};
      end else begin
         b_val = {1'b0, x_ff} + {1'b0, a_val};
      end
      xn_diff = b_ff - md_quo;
   end

   // operand selection for the shared unit
   always_comb begin
      mul_a   = (state_ff == ST_BCALC) ? a_val : x_ff;
      div_num = (state_ff == ST_TEST) ? res_ff : RW'(md_prod);
      div_den = (state_ff == ST_TEST) ? {1'b0, x_ff, 1'b0} : {b_ff, 1'b0};
   end

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      x_in         = x_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      neg_in       = neg_ff;
      steps_in     = steps_ff;
      conv_in      = conv_ff;
      derr_in      = derr_ff;
      md_ctrl      = '{start: 1'b0, op: MD_MUL};
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      root_in      = root_ff;
      rconv_in     = rconv_ff;
      rderr_in     = rderr_ff;
      rsteps_in    = rsteps_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               s_in     = VW'(req_chan.radicand);
               x_in     = VW'(req_chan.start_guess);
               steps_in = '0;
               conv_in  = 1'b0;
               derr_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // step budget test, then x*x
            if (steps_ff < limit_ff) begin
               md_ctrl  = '{start: 1'b1, op: MD_MUL};
               state_in = ST_SQ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SQ: begin
            if (md_stat.done) begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            neg_in   = !diff[RW] && (diff[RW-1:0] != '0);
            res_in   = diff[RW] ? RW'((RW+1)'(0) - diff) : diff[RW-1:0];
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (res_ff < eps_al) begin
               conv_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (x_ff == '0) begin
               derr_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               // a = res / 2x
               md_ctrl  = '{start: 1'b1, op: MD_DIV};
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (md_stat.done) begin
               state_in = ST_BCALC;
            end
         end
         ST_BCALC: begin
            b_in = b_val;
            if (b_val == '0) begin
               derr_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               // a*a
               md_ctrl  = '{start: 1'b1, op: MD_MUL};
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (md_stat.done) begin
               // q = a*a / 2b
               md_ctrl  = '{start: 1'b1, op: MD_DIV};
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (md_stat.done) begin
               // x = b - q, floored at zero and saturated
               if (md_stat.ovf || (md_quo >= b_ff)) begin
                  x_in = '0;
               end else if (xn_diff[VW]) begin
                  x_in = VMAX;
               end else begin
                  x_in = xn_diff[VW-1:0];
               end
               steps_in = steps_ff + LIMIT_WIDTH'(1);
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               root_in      = 32'(x_ff);
               rconv_in     = conv_ff;
               rderr_in     = derr_ff;
               rsteps_in    = steps_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= EPSILON_RESET;
         limit_ff     <= ITER_LIMIT_RESET;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         eps_ff       <= eps_in;
         limit_ff     <= limit_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff      <= s_in;
      x_ff      <= x_in;
      b_ff      <= b_in;
      res_ff    <= res_in;
      neg_ff    <= neg_in;
      steps_ff  <= steps_in;
      conv_ff   <= conv_in;
      derr_ff   <= derr_in;
      root_ff   <= root_in;
      rconv_ff  <= rconv_in;
      rderr_ff  <= rderr_in;
      rsteps_ff <= rsteps_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.root       = root_ff;
   assign rsp_chan.converged  = rconv_ff;
   assign rsp_chan.div_error  = rderr_ff;
   assign rsp_chan.steps_used = rsteps_ff;

endmodule

`default_nettype wire

// ===== test/bsr_test_if.sv =====
// ----------------------------------------------------------------------------
// bsr test interfaces
// the unit's request and response channel interfaces are reused as they stand;
// this file holds the transaction types shared by the test bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsr_test_pkg;

   typedef struct packed {
      logic [31:0] radicand;
      logic [31:0] start_guess;
   } sqrt_request_type;

   typedef struct packed {
      logic [31:0] root;
      logic        converged;
      logic        div_error;
      logic [7:0]  steps_used;
   } sqrt_result_type;

endpackage

// ===== test/bakhshali_square_root_unit_test.sv =====
// ----------------------------------------------------------------------------
// bakhshali_square_root_unit_test
// drives radicand/guess transactions through the unit under several tolerance
// and step-limit settings, predicts each result in fixed point and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bakhshali_square_root_unit_test
   import bsr_pkg::*;
   import bsr_test_pkg::*;
();

   localparam int FRAC     = 16;
   localparam int WATCHDOG = 200000;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [31:0] csr_write_data;

   bsr_req_if u_req ();
   bsr_rsp_if u_rsp ();

   bakhshali_square_root_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (u_req),
      .rsp_chan       (u_rsp),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   sqrt_request_type pending_requests[$];
   sqrt_result_type  expected_roots[$];

   // model copy of the two registers
   logic [31:0] tolerance;
   logic [7:0]  step_limit;

   int  mismatches;
   int  idle_cycles;
   bit  quiet;          // no idling in the closing part of the run
   int  send_gap;
   int  recv_gap;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // bakhshali refinement at full width, quotients truncated
   function automatic sqrt_result_type refine_root(logic [31:0] s_in, logic [31:0] x_in);
      logic [127:0] vmax;
      logic [127:0] x;
      logic [127:0] s_al;
      logic [127:0] eps_al;
      logic [127:0] sq;
      logic [127:0] res;
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] q;
      logic         neg;
      sqrt_result_type r;
      int steps;
      vmax   = (128'd1 << 32) - 128'd1;
      x      = 128'(x_in);
      s_al   = {96'd0, s_in} << FRAC;
      eps_al = {96'd0, tolerance} << FRAC;
      steps  = 0;
      r.converged = 1'b0;
      r.div_error = 1'b0;
      while (steps < step_limit) begin
         sq  = x * x;
         neg = sq > s_al;
         res = neg ? sq - s_al : s_al - sq;
         if (res < eps_al) begin
            r.converged = 1'b1;
            break;
         end
         // zero guess: no divisor for the correction
         if (x == 128'd0) begin
            r.div_error = 1'b1;
            break;
         end
         a = res / (x * 128'd2);
         if (a > vmax) a = vmax;
         b = neg ? ((a >= x) ? 128'd0 : x - a) : x + a;
         if (b == 128'd0) begin
            r.div_error = 1'b1;
            break;
         end
         q = (a * a) / (b * 128'd2);
         // a second correction that swallows b drives x to zero
         x = (q >= b) ? 128'd0 : b - q;
         if (x > vmax) x = vmax;
         steps++;
      end
      r.root       = x[31:0];
      r.steps_used = steps[7:0];
      return r;
   endfunction

   // integer square root of s << 16, i.e. the exact root in fixed point
   function automatic logic [31:0] exact_root(logic [31:0] s);
      logic [63:0] n;
      logic [63:0] root;
      logic [63:0] bitv;
      n    = {32'd0, s} << FRAC;
      root = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   // request driver: pops pending transactions, inserts random gaps
   always @(posedge clock) begin
      if (reset) begin
         u_req.valid       <= 1'b0;
         u_req.radicand    <= '0;
         u_req.start_guess <= '0;
         send_gap          <= 0;
      end else if (!u_req.valid || u_req.ready) begin
         if (send_gap > 0) begin
            send_gap    <= send_gap - 1;
            u_req.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            sqrt_request_type item;
            item = pending_requests.pop_front();
            u_req.valid       <= 1'b1;
            u_req.radicand    <= item.radicand;
            u_req.start_guess <= item.start_guess;
            if (!quiet && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 4);
         end else begin
            u_req.valid <= 1'b0;
         end
      end
   end

   // response ready with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         u_rsp.ready <= 1'b0;
         recv_gap    <= 0;
      end else if (recv_gap > 0) begin
         recv_gap    <= recv_gap - 1;
         u_rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         recv_gap    <= $urandom_range(0, 3);
         u_rsp.ready <= 1'b0;
      end else begin
         u_rsp.ready <= 1'b1;
      end
   end

   // accepted request transactions feed the prediction queue
   always @(posedge clock) begin
      if (!reset && u_req.valid && u_req.ready)
         expected_roots.push_back(refine_root(u_req.radicand, u_req.start_guess));
   end

   // response monitor and compare
   always @(posedge clock) begin
      if (!reset && u_rsp.valid && u_rsp.ready) begin
         sqrt_result_type got;
         sqrt_result_type want;
         got.root       = u_rsp.root;
         got.converged  = u_rsp.converged;
         got.div_error  = u_rsp.div_error;
         got.steps_used = u_rsp.steps_used;
         if (expected_roots.size() == 0) begin
            $display("%0t: unexpected response root=%h conv=%b derr=%b steps=%0d",
                     $time, got.root, got.converged, got.div_error, got.steps_used);
            mismatches++;
         end else begin
            want = expected_roots.pop_front();
            if (got.root !== want.root) begin
               $display("%0t: root expected %h actual %h", $time, want.root, got.root);
               mismatches++;
            end
            if (got.converged !== want.converged) begin
               $display("%0t: converged expected %b actual %b", $time,
                        want.converged, got.converged);
               mismatches++;
            end
            if (got.div_error !== want.div_error) begin
               $display("%0t: div_error expected %b actual %b", $time,
                        want.div_error, got.div_error);
               mismatches++;
            end
            if (got.steps_used !== want.steps_used) begin
               $display("%0t: steps_used expected %0d actual %0d", $time,
                        want.steps_used, got.steps_used);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (u_req.valid && u_req.ready) || (u_rsp.valid && u_rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic queue_request(logic [31:0] s, logic [31:0] g);
      sqrt_request_type item;
      item.radicand    = s;
      item.start_guess = g;
      pending_requests.push_back(item);
   endtask

   // random content: mostly guesses near the true root, some far off
   task automatic queue_random(int count);
      logic [31:0] s;
      logic [31:0] g;
      int          pick;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: s = $urandom;
            3, 4:    s = $urandom_range(0, 32'h0000_FFFF);
            5:       s = $urandom >> $urandom_range(0, 31);
            default: s = $urandom_range(0, 32'h0FFF_FFFF);
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 6) g = exact_root(s) + $urandom_range(0, 32'h1_0000) + 32'd1;
         else if (pick < 8) g = exact_root(s) >> $urandom_range(0, 4);
         else if (pick < 9) g = $urandom;
         else g = $urandom_range(0, 3);
         queue_request(s, g);
      end
   endtask

   // waits until every transaction of the phase has come back
   task automatic drain_phase();
      while (pending_requests.size() != 0 || expected_roots.size() != 0 || u_req.valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic index, logic [31:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      if (index == CSR_EPSILON) tolerance = value;
      else step_limit = value[7:0];
      @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_EPSILON;
      csr_write_data = '0;
      u_req.valid       = 1'b0;
      u_req.radicand    = '0;
      u_req.start_guess = '0;
      u_rsp.ready       = 1'b0;
      tolerance      = EPSILON_RESET;
      step_limit     = ITER_LIMIT_RESET;
      mismatches     = 0;
      idle_cycles    = 0;
      quiet          = 1'b0;
      send_gap       = 0;
      recv_gap       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset settings
      queue_request(32'h0000_0000, 32'h0000_0000);   // zero guess, already converged
      queue_request(32'hFFFF_FFFF, 32'h0000_0000);   // zero guess, division fault
      queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(32'hFFFF_FFFF, 32'h0000_0001);   // huge correction
      queue_request(32'h0000_0001, 32'hFFFF_FFFF);   // guess far above the root
      queue_request(32'h0004_0000, 32'h0002_0000);   // exact square
      queue_request(32'h0002_0000, 32'h0001_0000);
      queue_request(32'h0000_0000, 32'h0000_0001);
      queue_request(32'h0000_0000, 32'h8000_0000);   // zero radicand, guess far above the root
      queue_request(32'h0001_0000, 32'h0000_0100);
      queue_request(32'h8000_0000, 32'h00B5_0000);
      queue_request(32'h0000_FFFF, 32'h0000_FFFF);
      queue_random(120);
      drain_phase();

      // zero tolerance never converges; short limit keeps it cheap
      write_register(CSR_EPSILON, 32'h0000_0000);
      write_register(CSR_ITER_LIMIT, 32'd3);
      queue_request(32'h0000_0000, 32'h0000_0000);
      queue_request(32'h0000_0000, 32'h0001_0000);
      queue_request(32'h0004_0000, 32'h0002_0000);
      queue_request(32'h0000_0001, 32'hFFFF_FFFF);
      queue_random(60);
      drain_phase();

      // zero limit hands back the guess untouched
      write_register(CSR_EPSILON, 32'hFFFF_FFFF);
      write_register(CSR_ITER_LIMIT, 32'd0);
      queue_request(32'hFFFF_FFFF, 32'h0000_0000);
      queue_random(40);
      drain_phase();

      // largest limit, largest tolerance: most pass the first test
      write_register(CSR_ITER_LIMIT, 32'd255);
      queue_random(40);
      drain_phase();

      // largest limit with zero tolerance: only a few, each runs all steps
      write_register(CSR_EPSILON, 32'h0000_0000);
      queue_request(32'h0002_0000, 32'h0001_0000);
      queue_request(32'h0000_0000, 32'h0000_0001);
      queue_request($urandom, $urandom);
      drain_phase();

      // a few random settings
      repeat (4) begin
         write_register(CSR_EPSILON, $urandom >> $urandom_range(0, 31));
         write_register(CSR_ITER_LIMIT, $urandom_range(1, 20));
         queue_random(90);
         drain_phase();
      end

      // back to the reset values, closing part without idling
      write_register(CSR_EPSILON, EPSILON_RESET);
      write_register(CSR_ITER_LIMIT, 32'(ITER_LIMIT_RESET));
      queue_random(100);
      drain_phase();
      quiet = 1'b1;
      queue_random(80);
      drain_phase();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
